[src/woi_pkg.sv]
package woi_pkg;

  // shared shift-add multiplier: multiplicand x multiplier, one multiplier bit per cycle
  localparam int MA_W   = 58;
  localparam int MB_W   = 40;
  localparam int PROD_W = MA_W + MB_W;

  // CORDIC datapath width and start value (gain compensation, Q30)
  localparam int CORD_W = 34;
  localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD = 2'd1;

  // atan(2^-i) as binary angle, full circle = 2^32
  function automatic logic [31:0] atan_lut(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[src/wheel_odometry_integrator.sv]
// Differential-drive wheel odometry.
// Input channel (in_valid/in_ready): one request carries absolute left and right
// encoder counts. Output channel (out_valid/out_ready): one pose per request,
// pos_x/pos_y signed with POS_FRAC_BITS fraction bits, heading as binary angle.
// Config channel (cfg_valid/cfg_ready, always ready): index 0 distance_per_count,
// index 1 heading_per_count; other indexes are dropped. Write only when idle.
// The first request after reset only latches the baseline; its pose passes
// through the hand-off state to the output register. Every later request
// runs four products (travel, heading change, x move, y move), each through
// one shared shift-add multiplier at one multiplier bit per cycle and then a
// rounding step; the CORDIC for cos/sin of the old heading runs one step a
// cycle in parallel with the first product; after the last product the
// hand-off state loads the output register. in_ready comes back together
// with out_valid, so a new request is taken only once the last pose is handed off.
// One request is worked on at a time; in_ready is high whenever the engine
// is free, even while an earlier pose still waits in the output register.
// A stalled receiver holds the pose in that register; the engine finishes the
// next request and waits in its hand-off state until the register frees up.
// Reset (rst, synchronous) clears the pose, baseline and both scale registers
// back to their defaults, and drops any pending pose.
module wheel_odometry_integrator
  import woi_pkg::*;
#(
  parameter int CORDIC_STEPS  = 24,
  parameter int POS_FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [31:0]   left_count,
  input  logic signed [31:0]   right_count,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [47:0]   pos_x,
  output logic signed [47:0]   pos_y,
  output logic        [31:0]   heading,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [39:0]          cfg_data
);

  localparam int DSH    = 32 - POS_FRAC_BITS;
  localparam int CNT_W  = $clog2(CORDIC_STEPS);
  localparam int MCNT_W = $clog2(MB_W);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_FIN, S_OUT} state_t;
  typedef enum logic [1:0] {OP_DIST, OP_HEAD, OP_X, OP_Y} op_t;

  state_t state;
  op_t    op;

  // config
  logic [31:0] dist_per_count;
  logic [39:0] head_per_count;

  // odometry state
  logic [31:0] prev_left, prev_right;
  logic        baseline_taken;
  logic [47:0] acc_x, acc_y;
  logic [31:0] acc_heading;

  // per-request working registers
  logic              dneg;       // travel sign
  logic              diff_neg;
  logic [32:0]       diff_mag;
  logic [MA_W-1:0]   dmag;       // travel magnitude
  logic              mv_neg;     // sign of the move being multiplied
  logic [MA_W-1:0]   ma;
  logic [PROD_W-1:0] prod;       // low bits double as the multiplier shifter
  logic [MCNT_W-1:0] mcnt;

  // CORDIC
  logic                     cbusy, cflip;
  logic [CNT_W-1:0]         ccnt;
  logic signed [CORD_W-1:0] cx, cy, cz;

  // ---- input deltas ----
  logic [31:0]        dl, dr;
  logic signed [32:0] sum_s, diff_s;
  logic [32:0]        sum_mag;

  assign dl      = left_count - prev_left;
  assign dr      = right_count - prev_right;
  assign sum_s   = {dl[31], dl} + {dr[31], dr};
  assign diff_s  = {dr[31], dr} - {dl[31], dl};
  assign sum_mag = sum_s[32] ? 33'(-sum_s) : 33'(sum_s);

  // fold heading into [-90, 90) degrees; a half turn negates cos and sin
  logic [31:0] fold_sum;
  logic        fold;
  assign fold_sum = acc_heading + 32'h40000000;
  assign fold     = fold_sum[31];

  // ---- CORDIC step ----
  logic signed [CORD_W-1:0] xs, ys, tz;
  assign xs = cx >>> ccnt;
  assign ys = cy >>> ccnt;
  assign tz = CORD_W'(atan_lut(5'(ccnt)));

  // ---- shift-add step ----
  logic [MA_W:0] madd;
  assign madd = {1'b0, prod[PROD_W-1:MB_W]} + (prod[0] ? {1'b0, ma} : '0);

  // ---- rounding of a finished product ----
  logic [PROD_W-1:0] half, rnd;
  logic [MA_W-1:0]   dist_mag;
  logic [31:0]       dh_mag, dh;
  logic [47:0]       mv_mag, mv;

  always_comb begin
    case (op)
      OP_DIST: half = PROD_W'(1) << (DSH - 1);
      OP_HEAD: half = PROD_W'(1) << 15;
      default: half = PROD_W'(1) << 29;
    endcase
  end

  assign rnd      = prod + half;
  assign dist_mag = rnd[DSH +: MA_W];
  assign dh_mag   = rnd[16 +: 32];
  assign mv_mag   = rnd[30 +: 48];
  assign dh       = diff_neg ? -dh_mag : dh_mag;
  assign mv       = mv_neg ? -mv_mag : mv_mag;

  // cos/sin with the fold applied, as sign and magnitude
  logic signed [CORD_W-1:0] c_val, s_val;
  logic [CORD_W-1:0]        c_mag, s_mag;
  assign c_val = cflip ? -cx : cx;
  assign s_val = cflip ? -cy : cy;
  assign c_mag = c_val[CORD_W-1] ? CORD_W'(-c_val) : CORD_W'(c_val);
  assign s_mag = s_val[CORD_W-1] ? CORD_W'(-s_val) : CORD_W'(s_val);

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      op             <= OP_DIST;
      dist_per_count <= 32'd2147484;
      head_per_count <= 40'd447981339018;
      prev_left      <= '0;
      prev_right     <= '0;
      baseline_taken <= 1'b0;
      acc_x          <= '0;
      acc_y          <= '0;
      acc_heading    <= '0;
      out_valid      <= 1'b0;
      cbusy          <= 1'b0;
      ccnt           <= '0;
      mcnt           <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_DIST: dist_per_count <= cfg_data[31:0];
          REG_HEAD: head_per_count <= cfg_data;
          default: ;
        endcase
      end

      // the hand-off state reloads the register itself
      if (out_valid && out_ready && state != S_OUT) out_valid <= 1'b0;

      if (cbusy) begin
        if (cz >= 0) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - tz;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + tz;
        end
        ccnt <= ccnt + 1'b1;
        if (ccnt == CNT_W'(CORDIC_STEPS - 1)) cbusy <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            prev_left      <= left_count;
            prev_right     <= right_count;
            baseline_taken <= 1'b1;
            if (baseline_taken) begin
              dneg     <= sum_s[32];
              diff_neg <= diff_s[32];
              diff_mag <= diff_s[32] ? 33'(-diff_s) : 33'(diff_s);
              ma       <= MA_W'(sum_mag);
              prod     <= PROD_W'({8'd0, dist_per_count});
              mcnt     <= '0;
              op       <= OP_DIST;
              cflip    <= fold;
              cx       <= CORDIC_GAIN;
              cy       <= '0;
              cz       <= CORD_W'($signed({acc_heading[31] ^ fold, acc_heading[30:0]}));
              ccnt     <= '0;
              cbusy    <= 1'b1;
              state    <= S_MUL;
            end else begin
              state <= S_OUT;
            end
          end
        end
        S_MUL: begin
          prod <= {madd, prod[MB_W-1:1]};
          mcnt <= mcnt + 1'b1;
          if (mcnt == MCNT_W'(MB_W - 1)) state <= S_FIN;
        end
        S_FIN: begin
          mcnt <= '0;
          unique case (op)
            OP_DIST: begin
              dmag  <= dist_mag;
              ma    <= MA_W'(diff_mag);
              prod  <= PROD_W'(head_per_count);
              op    <= OP_HEAD;
              state <= S_MUL;
            end
            OP_HEAD: begin
              acc_heading <= acc_heading + dh;
              ma          <= dmag;
              prod        <= PROD_W'(c_mag);
              mv_neg      <= c_val[CORD_W-1] ^ dneg;
              op          <= OP_X;
              state       <= S_MUL;
            end
            OP_X: begin
              acc_x  <= acc_x + mv;
              prod   <= PROD_W'(s_mag);
              mv_neg <= s_val[CORD_W-1] ^ dneg;
              op     <= OP_Y;
              state  <= S_MUL;
            end
            default: begin
              acc_y <= acc_y + mv;
              state <= S_OUT;
            end
          endcase
        end
        default: begin
          if (!out_valid || out_ready) begin
            pos_x     <= acc_x;
            pos_y     <= acc_y;
            heading   <= acc_heading;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  // CORDIC must be done before cos is used
  assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN && op == OP_HEAD) |-> !cbusy)
    else $error("cordic still running at x product load");

  // one request at a time
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request accepted while busy");

  // a pose appears only from the hand-off state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("pose issued outside hand-off");

  // heading only moves during the heading rounding cycle
  assert property (@(posedge clk) disable iff (rst)
    !(state == S_FIN && op == OP_HEAD) |=> $stable(acc_heading))
    else $error("heading changed unexpectedly");
`endif

endmodule
